/* src/gba_pkg.sv */
`timescale 1ns / 1ps

package gba_pkg;

  // default iteration count and the most the angle table supports
  localparam int CordicStagesDef = 16;
  localparam int AtanTableLen    = 24;

  // goal direction codes
  localparam logic [8:0] DirN  = 9'd0;
  localparam logic [8:0] DirNe = 9'd45;
  localparam logic [8:0] DirE  = 9'd90;
  localparam logic [8:0] DirSe = 9'd135;
  localparam logic [8:0] DirS  = 9'd180;
  localparam logic [8:0] DirSw = 9'd225;
  localparam logic [8:0] DirW  = 9'd270;
  localparam logic [8:0] DirNw = 9'd315;

  // target square half side in cm
  localparam logic signed [8:0] HalfSide = 9'sd150;

  // widths: dx/dy are 17 bit, scaled by 2^16, plus cordic gain and rotation headroom
  localparam int DeltaW = 17;
  localparam int FracW  = 16;
  localparam int XyW    = 36;
  localparam int PhaseW = 32;

  // bearing scale: 360 degrees in 1/16 degree units
  localparam int BearingW = 13;
  localparam logic [BearingW-1:0] BearingFull = 13'd5760;
  localparam int ProdW = PhaseW + BearingW;

  // one cordic beat moving down the chain
  typedef struct packed {
    logic                    vld;
    logic                    zero;
    logic signed [XyW-1:0]   x;
    logic signed [XyW-1:0]   y;
    logic [PhaseW-1:0]       phase;
  } cordic_t;

  // atan(2^-i) as a fraction of the full circle, 2^32 = 360 degrees
  function automatic logic [PhaseW-1:0] atan_phase(input int idx);
    logic [PhaseW-1:0] v;
    unique case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* src/gba_front.sv */
`timescale 1ns / 1ps

module gba_front import gba_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  logic [8:0]          goal_dir,
  input  logic signed [15:0]  pos_x,
  input  logic signed [15:0]  pos_y,
  output cordic_t             out
);

  logic signed [8:0]        tx;
  logic signed [8:0]        ty;
  logic signed [DeltaW-1:0] dx;
  logic signed [DeltaW-1:0] dy;
  logic signed [XyW-1:0]    x0;
  logic signed [XyW-1:0]    y0;
  cordic_t                  out_next;

  // goal code to target point, unknown codes aim at the origin
  always_comb begin
    tx = '0;
    ty = '0;
    unique case (goal_dir)
      DirN:    begin tx = '0;        ty = HalfSide;  end
      DirNe:   begin tx = HalfSide;  ty = HalfSide;  end
      DirE:    begin tx = HalfSide;  ty = '0;        end
      DirSe:   begin tx = HalfSide;  ty = -HalfSide; end
      DirS:    begin tx = '0;        ty = -HalfSide; end
      DirSw:   begin tx = -HalfSide; ty = -HalfSide; end
      DirW:    begin tx = -HalfSide; ty = '0;        end
      DirNw:   begin tx = -HalfSide; ty = HalfSide;  end
      default: begin tx = '0;        ty = '0;        end
    endcase
  end

  // vector to target, scaled into the cordic format
  always_comb begin
    dx = DeltaW'(tx) - DeltaW'(pos_x);
    dy = DeltaW'(ty) - DeltaW'(pos_y);
    x0 = XyW'(dy) <<< FracW;
    y0 = XyW'(dx) <<< FracW;
  end

  // fold the left half plane over by half a turn
  always_comb begin
    out_next.vld  = in_vld;
    out_next.zero = (dx == '0) && (dy == '0);
    if (x0[XyW-1]) begin
      out_next.x     = -x0;
      out_next.y     = -y0;
      out_next.phase = {1'b1, {(PhaseW-1){1'b0}}};
    end else begin
      out_next.x     = x0;
      out_next.y     = y0;
      out_next.phase = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.vld <= 1'b0;
    end else if (en) begin
      out <= out_next;
    end
  end

endmodule

/* src/gba_cell.sv */
`timescale 1ns / 1ps

module gba_cell import gba_pkg::*; #(
  parameter int Stage = 0
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  cordic_t in,
  output cordic_t out
);

  localparam logic [PhaseW-1:0] Atan = atan_phase(Stage);

  logic signed [XyW-1:0] xs;
  logic signed [XyW-1:0] ys;
  cordic_t               out_next;

  // one vectoring micro-rotation, steering y toward zero
  always_comb begin
    xs            = in.x >>> Stage;
    ys            = in.y >>> Stage;
    out_next.vld  = in.vld;
    out_next.zero = in.zero;
    if (!in.y[XyW-1]) begin
      out_next.x     = in.x + ys;
      out_next.y     = in.y - xs;
      out_next.phase = in.phase + Atan;
    end else begin
      out_next.x     = in.x - ys;
      out_next.y     = in.y + xs;
      out_next.phase = in.phase - Atan;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.vld <= 1'b0;
    end else if (en) begin
      out <= out_next;
    end
  end

endmodule

/* src/gba_back.sv */
`timescale 1ns / 1ps

module gba_back import gba_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cordic_t             in,
  output logic                en,
  output logic                out_vld,
  input  logic                out_rdy,
  output logic [BearingW-1:0] bearing
);

  logic                prod_vld;
  logic                prod_zero;
  logic [ProdW-1:0]    prod;
  logic [ProdW:0]      rounded;
  logic [BearingW:0]   r;
  logic [BearingW-1:0] res;
  logic                skid_vld;
  logic [BearingW-1:0] skid_data;
  logic                take;

  // chain advances while the skid slot is free
  assign en   = !skid_vld;
  assign take = prod_vld && en;

  // phase times degrees-per-turn in 1/16 units
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else if (en) begin
      prod_vld  <= in.vld;
      prod_zero <= in.zero;
      prod      <= ProdW'(in.phase) * ProdW'(BearingFull);
    end
  end

  // round half up, wrap a full turn, zero vector gives north
  always_comb begin
    rounded = {1'b0, prod} + (ProdW+1)'(64'h80000000);
    r       = rounded[ProdW:PhaseW];
    if (prod_zero || (r >= (BearingW+1)'(BearingFull))) begin
      res = '0;
    end else begin
      res = r[BearingW-1:0];
    end
  end

  // output register with skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else if (!out_vld || out_rdy) begin
      if (skid_vld) begin
        out_vld  <= 1'b1;
        bearing  <= skid_data;
        skid_vld <= 1'b0;
      end else begin
        out_vld <= take;
        bearing <= res;
      end
    end else if (take) begin
      skid_vld  <= 1'b1;
      skid_data <= res;
    end
  end

  // skid slot only fills behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> out_vld)
    else $error("skid slot full with empty output register");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (!skid_vld && take && out_vld && !out_rdy) |=> skid_vld)
    else $error("beat taken from chain was not parked in skid slot");

  a_bearing_range: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> (bearing < BearingFull))
    else $error("bearing out of range");

  a_zero_north: assert property (@(posedge clk) disable iff (rst)
    (take && prod_zero && !out_vld) |=> (out_vld && bearing == '0))
    else $error("zero vector did not give bearing zero");

endmodule

/* src/goal_bearing_atan2.sv */
`timescale 1ns / 1ps

// Compass bearing from a position to one of eight goal points on a square
// of half side 150 cm (any other goal code aims at the origin), returned in
// 1/16 degree clockwise from north, 0 to 5759. Fully pipelined: one beat is
// accepted every cycle while the skid slot is empty, and each beat passes the
// decode stage, one cordic cell per iteration (min(CORDIC_STAGES, 24) cells),
// the product stage and the output register. An output register with a skid
// slot keeps the input side open for one more beat while a result waits on
// the downstream side.

module goal_bearing_atan2 import gba_pkg::*; #(
  parameter int CORDIC_STAGES = CordicStagesDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // goal_dir[8:0], pos_x[24:9], pos_y[40:25], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // bearing[12:0], zero pad
);

  localparam int NumStages = (CORDIC_STAGES > AtanTableLen) ? AtanTableLen : CORDIC_STAGES;

  logic                en;
  logic [BearingW-1:0] bearing;
  cordic_t             chain [NumStages+1];

  assign s_axis_tready = en;
  assign m_axis_tdata  = {(16-BearingW)'(0), bearing};

  // decode and pre-rotation
  gba_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s_axis_tvalid),
    .goal_dir (s_axis_tdata[8:0]),
    .pos_x    (s_axis_tdata[24:9]),
    .pos_y    (s_axis_tdata[40:25]),
    .out      (chain[0])
  );

  // one cell per cordic iteration
  for (genvar i = 0; i < NumStages; i++) begin : g_cell
    gba_cell #(.Stage(i)) u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .in  (chain[i]),
      .out (chain[i+1])
    );
  end

  // scale, round and output buffering
  gba_back u_back (
    .clk     (clk),
    .rst     (rst),
    .in      (chain[NumStages]),
    .en      (en),
    .out_vld (m_axis_tvalid),
    .out_rdy (m_axis_tready),
    .bearing (bearing)
  );

endmodule
